/* rtl/multichannel_pattern_lock_defines.svh */
// ---------------------------------------------------------------------------
// multichannel_pattern_lock_defines
// assertion macros shared by the pattern lock design
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_PATTERN_LOCK_DEFINES_SVH
`define MULTICHANNEL_PATTERN_LOCK_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pattern lock check failed");

// next-cycle implication, sampled on clk, off during rst
`define MPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pattern lock check failed");

`endif

/* rtl/mpl_pkg.sv */
// ---------------------------------------------------------------------------
// mpl_pkg
// shared constants and types of the multichannel pattern lock
// ---------------------------------------------------------------------------
package mpl_pkg;

  localparam int CHANNELS          = 4;
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int CHAN_W            = 2;
  localparam int BYTE_W            = 8;
  localparam int WIN_W             = 64;
  localparam int LEN_W             = 4;
  localparam int CNT_W             = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_LENGTH  = 2'd2,
    CFG_COUNT   = 2'd3
  } cfg_index_t;

  localparam logic KIND_FWD  = 1'b0;
  localparam logic KIND_LOCK = 1'b1;

  typedef logic [WIN_W-1:0] window_t;

  typedef struct packed {
    logic    hit;
    logic    write;
    window_t window;
  } match_t;

endpackage

/* rtl/mpl_ram.sv */
// ---------------------------------------------------------------------------
// mpl_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
module mpl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mpl_match.sv */
// ---------------------------------------------------------------------------
// mpl_match
// window shift and masked pattern compare for one item
// ---------------------------------------------------------------------------
module mpl_match (
  input  mpl_pkg::window_t                win_old,
  input  logic [mpl_pkg::BYTE_W-1:0]      data,
  input  logic [mpl_pkg::WIN_W-1:0]       pattern,
  input  logic [mpl_pkg::MAX_PATTERN_BYTES-1:0] mask,
  input  logic [mpl_pkg::LEN_W-1:0]       length,
  output mpl_pkg::match_t                 res
);

  logic [mpl_pkg::LEN_W-1:0]             eff_len;
  mpl_pkg::window_t                      old_sh;
  mpl_pkg::window_t                      win_new;
  logic [mpl_pkg::MAX_PATTERN_BYTES-1:0] ok;

  assign eff_len = (length > mpl_pkg::LEN_W'(mpl_pkg::MAX_PATTERN_BYTES)) ?
                   mpl_pkg::LEN_W'(mpl_pkg::MAX_PATTERN_BYTES) : length;
  assign old_sh  = win_old >> mpl_pkg::BYTE_W;

  always_comb begin
    win_new = '0;
    ok      = '1;
    for (int l = 0; l < mpl_pkg::MAX_PATTERN_BYTES; l++) begin
      if (mpl_pkg::LEN_W'(l + 1) < eff_len) begin
        win_new[l*mpl_pkg::BYTE_W +: mpl_pkg::BYTE_W] =
          old_sh[l*mpl_pkg::BYTE_W +: mpl_pkg::BYTE_W];
      end else if (mpl_pkg::LEN_W'(l + 1) == eff_len) begin
        win_new[l*mpl_pkg::BYTE_W +: mpl_pkg::BYTE_W] = data;
      end
      if (mask[l] && (mpl_pkg::LEN_W'(l) < eff_len)) begin
        ok[l] = (win_new[l*mpl_pkg::BYTE_W +: mpl_pkg::BYTE_W] ==
                 pattern[l*mpl_pkg::BYTE_W +: mpl_pkg::BYTE_W]);
      end
    end
  end

  assign res.hit    = (eff_len == '0) || (&ok);
  assign res.write  = (eff_len != '0);
  assign res.window = win_new;

endmodule

/* rtl/multichannel_pattern_lock.sv */
// ---------------------------------------------------------------------------
// multichannel_pattern_lock
// locks to the first channel whose byte window matches a masked pattern
// ---------------------------------------------------------------------------
// Takes one item per clock cycle sustained while the output is not held. Each
// item passes through the item stage register into the output register; a
// held output stalls the item stage and the input. Each channel's window sits
// in a small synchronous ram: the channel is read when the item is taken, and
// the item stage shifts in the byte, runs the masked compare and writes the
// window back as it advances. When two items of one channel follow each other,
// the written window is forwarded to the second. Per-entry valid bits make
// unwritten windows read as zero after reset, so no clearing pass is needed.
// Once locked, only reset unlocks; configuration is to be written by the user
// only while the block is idle, and the block itself does not enforce this.
`include "multichannel_pattern_lock_defines.svh"

module multichannel_pattern_lock (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [mpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpl_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // data
  input  logic [1:0]                        s_tuser,  // channel
  input  logic                              s_tlast,  // buffer_end
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,  // out_byte
  output logic [2:0]                        m_tuser,  // kind, lock_channel
  output logic                              m_tlast   // out_end
);

  logic [mpl_pkg::WIN_W-1:0]             pattern_bytes;
  logic [mpl_pkg::MAX_PATTERN_BYTES-1:0] mask_bits;
  logic [mpl_pkg::LEN_W-1:0]             pattern_length;
  logic [mpl_pkg::CNT_W-1:0]             channel_count;

  logic                                  locked;
  logic [mpl_pkg::CHAN_W-1:0]            locked_chan;
  logic                                  drop_rest;
  logic [mpl_pkg::CHANNELS-1:0]          win_valid;

  logic                                  s1_valid;
  logic [mpl_pkg::CHAN_W-1:0]            s1_chan;
  logic [mpl_pkg::BYTE_W-1:0]            s1_data;
  logic                                  s1_end;
  logic                                  s1_fwd;
  mpl_pkg::window_t                      s1_fwd_win;

  logic                                  accept;
  logic                                  advance;
  logic                                  watched;
  logic                                  win_we;
  logic                                  emit;
  logic                                  emit_kind;
  logic [mpl_pkg::CNT_W-1:0]             eff_ch;
  mpl_pkg::window_t                      ram_rdata;
  mpl_pkg::window_t                      win_old;
  mpl_pkg::match_t                       mres;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      mask_bits      <= '0;
      pattern_length <= '0;
      channel_count  <= '0;
    end else if (cfg_we) begin
      unique case (mpl_pkg::cfg_index_t'(cfg_index))
        mpl_pkg::CFG_PATTERN: pattern_bytes  <= cfg_data;
        mpl_pkg::CFG_MASK:    mask_bits      <= cfg_data[mpl_pkg::MAX_PATTERN_BYTES-1:0];
        mpl_pkg::CFG_LENGTH:  pattern_length <= cfg_data[mpl_pkg::LEN_W-1:0];
        mpl_pkg::CFG_COUNT:   channel_count  <= cfg_data[mpl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mpl_ram #(
    .WIDTH (mpl_pkg::WIN_W),
    .DEPTH (mpl_pkg::CHANNELS)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (s1_chan),
    .wdata (mres.window),
    .re    (accept),
    .raddr (s_tuser),
    .rdata (ram_rdata)
  );

  assign win_old = s1_fwd ? s1_fwd_win :
                   (win_valid[s1_chan] ? ram_rdata : '0);

  mpl_match u_match (
    .win_old (win_old),
    .data    (s1_data),
    .pattern (pattern_bytes),
    .mask    (mask_bits),
    .length  (pattern_length),
    .res     (mres)
  );

  assign eff_ch  = (channel_count > mpl_pkg::CNT_W'(mpl_pkg::CHANNELS)) ?
                   mpl_pkg::CNT_W'(mpl_pkg::CHANNELS) : channel_count;
  assign watched = !locked && ({1'b0, s1_chan} < eff_ch);
  assign win_we  = s1_valid && advance && watched && mres.write;

  always_comb begin
    emit      = 1'b0;
    emit_kind = mpl_pkg::KIND_FWD;
    if (locked) begin
      emit = (s1_chan == locked_chan) && !drop_rest;
    end else if (watched && mres.hit) begin
      emit      = 1'b1;
      emit_kind = mpl_pkg::KIND_LOCK;
    end
  end

  // item stage, lock state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s1_fwd      <= 1'b0;
      locked      <= 1'b0;
      locked_chan <= '0;
      drop_rest   <= 1'b0;
      win_valid   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid   <= 1'b1;
        s1_chan    <= s_tuser;
        s1_data    <= s_tdata;
        s1_end     <= s_tlast;
        s1_fwd     <= win_we && (s1_chan == s_tuser);
        s1_fwd_win <= mres.window;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= s1_valid && emit;
      end
      if (s1_valid && advance) begin
        if (win_we) begin
          win_valid[s1_chan] <= 1'b1;
        end
        if (locked) begin
          if ((s1_chan == locked_chan) && drop_rest && s1_end) begin
            drop_rest <= 1'b0;
          end
        end else if (watched && mres.hit) begin
          locked      <= 1'b1;
          locked_chan <= s1_chan;
          drop_rest   <= !s1_end;
        end
        if (emit) begin
          m_tdata    <= s1_data;
          m_tuser    <= {(locked ? locked_chan : s1_chan), emit_kind};
          m_tlast    <= (emit_kind == mpl_pkg::KIND_FWD) ? s1_end : 1'b0;
        end
      end
    end
  end

  `MPL_ASSERT_NEXT(a_lock_sticks, locked, locked)
  `MPL_ASSERT_IMP(a_drop_needs_lock, drop_rest, locked)
  `MPL_ASSERT_IMP(a_fwd_only_locked, m_tvalid && (m_tuser[0] == mpl_pkg::KIND_FWD),
    locked && (m_tuser[2:1] == locked_chan))
  `MPL_ASSERT_IMP(a_lock_no_end, m_tvalid && (m_tuser[0] == mpl_pkg::KIND_LOCK), !m_tlast)

endmodule

/* test/pattern_lock_checker.sv */
// ---------------------------------------------------------------------------
// pattern_lock_checker
// predicts and checks the output stream of the multichannel pattern lock
// ---------------------------------------------------------------------------
// Follows the configuration writes and every accepted input item. It keeps
// its own copy of the per-channel byte windows and the lock state. Each item
// that gives a lock or forward result queues that result. Every accepted
// output item is compared field by field with the oldest queued result.
// Mismatches are counted, and the count of queued results is visible outside.
module pattern_lock_checker
  import mpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,  // data
  input  logic [1:0]            s_tuser,  // channel
  input  logic                  s_tlast,  // buffer_end
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,  // out_byte
  input  logic [2:0]            m_tuser,  // kind, lock_channel
  input  logic                  m_tlast,  // out_end
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic              ends;
    logic [CHAN_W-1:0] chan;
  } lock_result_t;

  logic [WIN_W-1:0]  pattern;
  logic [7:0]        mask;
  logic [LEN_W-1:0]  span;
  logic [CNT_W-1:0]  watch_count;
  window_t           windows [CHANNELS];
  logic              locked;
  logic [CHAN_W-1:0] locked_chan;
  logic              dropping;
  lock_result_t      due_results [$];
  lock_result_t      got;
  lock_result_t      want;

  // shift a byte into a channel window and tell whether the masked compare hits
  function automatic logic slide_window(input logic [CHAN_W-1:0] ch,
                                        input logic [BYTE_W-1:0] val);
    int      len;
    window_t keep;
    window_t w;
    logic    hit;
    len = (span > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(span);
    if (len == 0) return 1'b1;
    keep = (len > 1) ? ((window_t'(1) << (8 * (len - 1))) - window_t'(1)) : '0;
    w = (windows[ch] >> 8) & keep;
    w |= window_t'(val) << (8 * (len - 1));
    windows[ch] = w;
    hit = 1'b1;
    for (int l = 0; l < len; l++)
      if (mask[l] && (w[8*l +: 8] != pattern[8*l +: 8])) hit = 1'b0;
    return hit;
  endfunction

  function automatic int watched_channels();
    return (watch_count > CHANNELS) ? CHANNELS : int'(watch_count);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pattern = '0;
      mask = '0;
      span = '0;
      watch_count = '0;
      for (int c = 0; c < CHANNELS; c++) windows[c] = '0;
      locked = 1'b0;
      locked_chan = '0;
      dropping = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN: pattern = cfg_data;
          CFG_MASK:    mask = cfg_data[7:0];
          CFG_LENGTH:  span = cfg_data[LEN_W-1:0];
          CFG_COUNT:   watch_count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.kind = m_tuser[0];
        got.chan = m_tuser[2:1];
        got.value = m_tdata;
        got.ends = m_tlast;
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected output item: kind=%0d byte=%02h end=%0d chan=%0d",
                     got.kind, got.value, got.ends, got.chan);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.ends !== want.ends || got.chan !== want.chan) begin
            if (errors < 10) begin
              $write("mismatch: expected kind=%0d byte=%02h end=%0d chan=%0d, ",
                     want.kind, want.value, want.ends, want.chan);
              $display("got kind=%0d byte=%02h end=%0d chan=%0d",
                       got.kind, got.value, got.ends, got.chan);
            end
            errors++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (locked) begin
          if (s_tuser == locked_chan) begin
            if (dropping) begin
              if (s_tlast) dropping = 1'b0;
            end else begin
              due_results.push_back('{kind: KIND_FWD, value: s_tdata, ends: s_tlast,
                                      chan: locked_chan});
            end
          end
        end else if (int'(s_tuser) < watched_channels()) begin
          if (slide_window(s_tuser, s_tdata)) begin
            locked = 1'b1;
            locked_chan = s_tuser;
            dropping = !s_tlast;
            due_results.push_back('{kind: KIND_LOCK, value: s_tdata, ends: 1'b0,
                                    chan: s_tuser});
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the multichannel pattern lock
// ---------------------------------------------------------------------------
// Runs the block unlocked through many settings of pattern, mask, length and
// watched channels, feeding byte runs that miss the pattern by one compared
// byte plus random bytes on all channels. Then it sends a matching run on one
// channel, drops the rest of that buffer and streams random bytes through the
// locked channel. Both stream sides idle in random bursts, except at the end.
// A separate checker predicts and compares every output item.
module testbench;
  import mpl_pkg::*;

  localparam int IDLE_LIMIT      = 1000;
  localparam int UNLOCKED_PHASES = 12;
  localparam int PHASE_ITEMS     = 55;
  localparam int LOCKED_ITEMS    = 560;
  localparam int CALM_ITEMS      = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;  // data
  logic [1:0]            s_tuser = '0;  // channel
  logic                  s_tlast = 1'b0;  // buffer_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;  // out_byte
  logic [2:0]            m_tuser;  // kind, lock_channel
  logic                  m_tlast;  // out_end

  int         errors;
  int         pending;
  int         sent = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  logic [1:0] target;

  multichannel_pattern_lock DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  pattern_lock_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [1:0] ch, input logic [7:0] val, input logic ends);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ch;
    s_tdata <= val;
    s_tlast <= ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // wait for all results and for the pipeline to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_regs(input logic [63:0] pat, input logic [7:0] msk,
                           input logic [3:0] len, input logic [2:0] cnt);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_PATTERN;
    cfg_data <= pat;
    @(negedge clk);
    cfg_index <= CFG_MASK;
    cfg_data <= {56'd0, msk};
    @(negedge clk);
    cfg_index <= CFG_LENGTH;
    cfg_data <= {60'd0, len};
    @(negedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data <= {61'd0, cnt};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mask(input int len, input int need);
    logic [7:0] m;
    logic [7:0] live;
    m = 8'($urandom_range(0, 255));
    live = 8'((9'd1 << len) - 9'd1);
    while ($countones(m & live) < need) m[$urandom_range(0, len - 1)] = 1'b1;
    return m;
  endfunction

  // a run on one channel that misses the pattern in exactly one compared byte
  task automatic near_miss(input logic [1:0] ch, input int len,
                           input logic [63:0] pat, input logic [7:0] msk);
    int         bad;
    logic [7:0] val;
    bad = $urandom_range(0, len - 1);
    while (!msk[bad]) bad = $urandom_range(0, len - 1);
    for (int l = 0; l < len; l++) begin
      val = msk[l] ? pat[8*l +: 8] : 8'($urandom_range(0, 255));
      if (l == bad) val = val ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 2) == 0)
        send_byte(ch + 2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
      send_byte(ch, val, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int          len;
    int          eff;
    int          cnt;
    int          stop_at;
    logic [63:0] pat;
    logic [7:0]  msk;
    logic [1:0]  ch;
    logic        ends;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // nothing watched with reset settings
    send_byte(2'd0, 8'h00, 1'b0);
    send_byte(2'd3, 8'hFF, 1'b1);
    send_byte(2'd1, 8'h5A, 1'b0);
    send_byte(2'd2, 8'hA5, 1'b1);

    // zero length would match at once, only unwatched channels driven
    load_regs('1, 8'hFF, 4'd0, 3'd2);
    send_byte(2'd2, 8'hFF, 1'b0);
    send_byte(2'd3, 8'h00, 1'b1);
    send_byte(2'd3, 8'h81, 1'b0);

    // length and channel count above the maximum
    pat = 64'hA53C_00FF_5AC3_FF00;
    load_regs(pat, 8'hFF, 4'd15, 3'd7);
    near_miss(2'd3, MAX_PATTERN_BYTES, pat, 8'hFF);
    near_miss(2'd0, MAX_PATTERN_BYTES, pat, 8'hFF);
    send_byte(2'd1, 8'hFF, 1'b1);
    send_byte(2'd2, 8'h00, 1'b0);

    for (int p = 0; p < UNLOCKED_PHASES; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(3, 15);
      eff = (len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len;
      pat = {$urandom, $urandom};
      msk = pick_mask(eff, 3);
      cnt = $urandom_range(1, 7);
      load_regs(pat, msk, 4'(len), 3'(cnt));
      stop_at = sent + PHASE_ITEMS;
      while (sent < stop_at) begin
        if ($urandom_range(0, 3) != 0)
          near_miss(2'($urandom_range(0, 3)), eff, pat, msk);
        else
          send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
      end
    end

    // matching run on one watched channel
    len = $urandom_range(1, MAX_PATTERN_BYTES);
    cnt = $urandom_range(1, 7);
    eff = (cnt > CHANNELS) ? CHANNELS : cnt;
    target = 2'($urandom_range(0, eff - 1));
    pat = {$urandom, $urandom};
    msk = pick_mask(len, 1);
    load_regs(pat, msk, 4'(len), 3'(cnt));
    ends = 1'b0;
    for (int l = 0; l < len; l++) begin
      if (eff < CHANNELS && $urandom_range(0, 1) == 1)
        send_byte(2'($urandom_range(eff, CHANNELS - 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 1) == 1);
      ends = (l == len - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
      send_byte(target, msk[l] ? pat[8*l +: 8] : 8'($urandom_range(0, 255)), ends);
    end

    // rest of the locking buffer is dropped
    if (!ends) begin
      repeat ($urandom_range(0, 4)) begin
        send_byte(target + 2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 1) == 1);
        send_byte(target, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_byte(target, 8'($urandom_range(0, 255)), 1'b1);
    end

    for (int k = 0; k < LOCKED_ITEMS; k++) begin
      if (k == LOCKED_ITEMS / 3) load_regs('0, '0, '0, '0);
      if (k == 2 * LOCKED_ITEMS / 3) load_regs('1, 8'hFF, 4'd15, 3'd7);
      if (k >= LOCKED_ITEMS - CALM_ITEMS) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end else if (k % 100 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      ch = ($urandom_range(0, 1) == 1) ? target : 2'($urandom_range(0, 3));
      send_byte(ch, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
